### hdl/rcwc_pkg.sv
package rcwc_pkg;

   localparam int unsigned WIN_W = 16;
   localparam int unsigned SEQ_W = 32;
   localparam int unsigned MAXW_W = 11;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 96;
   localparam int unsigned RSP_DATA_W = 80;

   localparam logic [WIN_W-1:0] WIN_LIMIT = 16'hFFFF;
   localparam logic [WIN_W-1:0] RECOVERY_BONUS = 16'd3;
   localparam logic [1:0] DUP_TRIGGER = 2'd3;

   localparam logic [MAXW_W-1:0] MAX_WINDOW_RST = 11'd20;
   localparam logic [WIN_W-1:0] INIT_THRESH_RST = 16'd16;
   localparam logic [SEQ_W-1:0] START_SEQ_RST = 32'h0000_0002;
   localparam logic [WIN_W-1:0] CWND_RST = 16'd1;

   // event kinds
   localparam logic FUNC_ACK = 1'b0;
   localparam logic FUNC_TIMEOUT = 1'b1;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_WINDOW = 2'd0,
      CSR_INIT_THRESH = 2'd1,
      CSR_START_SEQ = 2'd2,
      CSR_UNUSED = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic             func;
      logic [SEQ_W-1:0] ack_number;
      logic [SEQ_W-1:0] send_pointer;
      logic [SEQ_W-1:0] final_sequence;
   } item_type;

   typedef struct packed {
      logic [WIN_W-1:0] cwnd;
      logic [WIN_W-1:0] ssthresh;
      logic [SEQ_W-1:0] base;
      logic [SEQ_W-1:0] dup_reference;
      logic [1:0]       dup_count;
      logic             recovery;
   } state_type;

   typedef struct packed {
      logic              go_back;
      logic              transfer_done;
      logic              in_fast_recovery;
      logic              base_advanced;
      logic [SEQ_W-1:0]  window_base;
      logic [MAXW_W-1:0] effective_window;
      logic [WIN_W-1:0]  threshold;
      logic [WIN_W-1:0]  congestion_window;
   } result_type;

endpackage

### hdl/rcwc_update.sv
module rcwc_update (
   input  rcwc_pkg::item_type   item,
   input  rcwc_pkg::state_type  state,
   input  logic [10:0]          max_window,
   output rcwc_pkg::state_type  state_next,
   output rcwc_pkg::result_type result
);
   import rcwc_pkg::*;

   logic [WIN_W:0]   dbl_sum;
   logic [WIN_W:0]   inc_sum;
   logic [WIN_W:0]   exit_sum;
   logic [SEQ_W-1:0] ack_delta;
   logic [SEQ_W:0]   partial_sum;
   logic [WIN_W-1:0] half_cwnd;
   logic [WIN_W:0]   fr_sum;
   logic [1:0]       dup_inc;
   logic [MAXW_W-1:0] mw;
   logic             done;
   logic             adv;

   always_comb begin
      dbl_sum     = {state.cwnd, 1'b0};
      inc_sum     = {1'b0, state.cwnd} + {{WIN_W{1'b0}}, 1'b1};
      exit_sum    = {1'b0, state.ssthresh} + {1'b0, RECOVERY_BONUS};
      ack_delta   = item.ack_number - state.base;
      partial_sum = {{(SEQ_W-WIN_W+1){1'b0}}, state.cwnd} + {1'b0, ack_delta};
      half_cwnd   = {1'b0, state.cwnd[WIN_W-1:1]};
      fr_sum      = {1'b0, half_cwnd} + {1'b0, RECOVERY_BONUS};
      dup_inc     = state.dup_count + 2'd1;
      done        = 1'b0;
      adv         = 1'b0;
      state_next  = state;

      priority if (item.func == FUNC_TIMEOUT) begin
         state_next.ssthresh = half_cwnd;
         state_next.cwnd     = CWND_RST;
      end else if (item.ack_number >= state.base && item.final_sequence != '0 &&
                   item.ack_number == item.final_sequence) begin
         done = 1'b1;
      end else if (item.ack_number > state.base) begin
         priority if (state.recovery) begin
            if (item.ack_number >= item.send_pointer) begin
               state_next.recovery = 1'b0;
               state_next.cwnd = exit_sum[WIN_W] ? WIN_LIMIT : exit_sum[WIN_W-1:0];
            end else begin
               state_next.cwnd = (partial_sum[SEQ_W:WIN_W] != '0) ? WIN_LIMIT
                                 : partial_sum[WIN_W-1:0];
            end
         end else if (state.cwnd < state.ssthresh) begin
            state_next.cwnd = dbl_sum[WIN_W] ? WIN_LIMIT : dbl_sum[WIN_W-1:0];
         end else begin
            state_next.cwnd = inc_sum[WIN_W] ? WIN_LIMIT : inc_sum[WIN_W-1:0];
         end
         state_next.base          = item.ack_number;
         state_next.dup_reference = item.ack_number;
         state_next.dup_count     = 2'd0;
         adv = 1'b1;
      end else if (item.ack_number == state.base) begin
         priority if (item.ack_number != state.dup_reference) begin
            state_next.dup_reference = item.ack_number;
            state_next.dup_count     = 2'd1;
         end else if (state.dup_count < DUP_TRIGGER) begin
            state_next.dup_count = dup_inc;
            if (dup_inc == DUP_TRIGGER) begin
               // third duplicate: halve and enter fast recovery
               state_next.ssthresh = half_cwnd;
               state_next.cwnd     = fr_sum[WIN_W-1:0];
               state_next.recovery = 1'b1;
            end
         end else begin
            state_next.dup_count = state.dup_count;
         end
      end else begin
         // stale ack, nothing moves
         state_next = state;
      end

      mw = (max_window == '0) ? {{(MAXW_W-1){1'b0}}, 1'b1} : max_window;

      result.congestion_window = state_next.cwnd;
      result.threshold         = state_next.ssthresh;
      result.effective_window  = (state_next.cwnd < {{(WIN_W-MAXW_W){1'b0}}, mw})
                                 ? state_next.cwnd[MAXW_W-1:0] : mw;
      result.window_base       = state_next.base;
      result.base_advanced     = adv;
      result.in_fast_recovery  = state_next.recovery;
      result.transfer_done     = done;
      result.go_back           = (item.func == FUNC_TIMEOUT);
   end

endmodule

### hdl/reno_congestion_window_control.sv
// Reno-style congestion window controller for a go-back-N sender.
//
// req channel: one word per event. tuser carries the event kind (ack or
// retransmission timeout), tdata the ack number, send pointer and final
// sequence. rsp channel: one word per event with the window state after it.
// csr port: single-cycle writes of max window, initial threshold and start
// sequence; writing the threshold or start sequence also loads the live
// threshold or window base. Writes are expected only while the block is idle.
//
// pipeline: an accepted word sits in the input register, and its result is
// loaded into the result register, whose valid flag drives rsp_tvalid.
// throughput: one event per cycle while the rsp side is not stalled; the window
// state is updated in the same edge that loads the result register, so the
// next event always sees it. A stalled rsp side holds the result and the input
// register fills, then req_tready drops; nothing is dropped or repeated.
//
// reset: window 1, threshold 16, base 2, max window 20, no duplicate
// tracking, not in recovery, both registers empty.
module reno_congestion_window_control (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // ack_number, send_pointer, final_sequence
   input  logic [0:0]  req_tuser,  // func

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // congestion_window, threshold, effective_window, window_base,
   // base_advanced, in_fast_recovery, transfer_done, go_back, zero pad
   output logic [79:0] rsp_tdata,

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import rcwc_pkg::*;

   // input register
   logic      in_valid_ff;
   logic      in_valid_in;
   item_type  in_item_ff;

   // result register
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_res_ff;

   // window state and settings
   state_type         state_ff;
   logic [MAXW_W-1:0] max_window_ff;

   state_type  state_next;
   result_type result;
   logic       advance;
   logic       req_fire;

   // result register frees up when empty or being drained this cycle
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   rcwc_update u_update (
      .item       (in_item_ff),
      .state      (state_ff),
      .max_window (max_window_ff),
      .state_next (state_next),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.func           <= req_tuser[0];
         in_item_ff.ack_number     <= req_tdata[31:0];
         in_item_ff.send_pointer   <= req_tdata[63:32];
         in_item_ff.final_sequence <= req_tdata[95:64];
      end
      if (advance) begin
         out_res_ff <= result;
      end
   end

   // window state, csr writes load settings and live copies
   always_ff @(posedge clock) begin
      if (reset) begin
         max_window_ff          <= MAX_WINDOW_RST;
         state_ff.cwnd          <= CWND_RST;
         state_ff.ssthresh      <= INIT_THRESH_RST;
         state_ff.base          <= START_SEQ_RST;
         state_ff.dup_reference <= '0;
         state_ff.dup_count     <= 2'd0;
         state_ff.recovery      <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAX_WINDOW:  max_window_ff     <= csr_wdata[MAXW_W-1:0];
            CSR_INIT_THRESH: state_ff.ssthresh <= csr_wdata[WIN_W-1:0];
            CSR_START_SEQ:   state_ff.base     <= csr_wdata[SEQ_W-1:0];
            CSR_UNUSED:      state_ff          <= state_ff;
            default:         state_ff          <= state_ff;
         endcase
      end else if (advance) begin
         state_ff <= state_next;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_res_ff};

   // a result never leaves with an empty window
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_res_ff.congestion_window != '0)
      else $error("zero congestion window in result");

   // effective window never exceeds the congestion window
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> {5'd0, out_res_ff.effective_window} <= out_res_ff.congestion_window)
      else $error("effective window above congestion window");

   // a timeout result always restarts from a window of one
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_res_ff.go_back) |-> out_res_ff.congestion_window == CWND_RST)
      else $error("timeout left window above one");

   // only one kind of event per result
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot0({out_res_ff.go_back, out_res_ff.transfer_done,
                                 out_res_ff.base_advanced}))
      else $error("conflicting event flags");

   // window state only moves when a result is loaded or a csr write lands
   assert property (@(posedge clock) disable iff (reset)
      (!advance && !csr_we) |=> $stable(state_ff))
      else $error("window state moved without an event");

   // the result register empties after reset
   assert property (@(posedge clock) reset |=> !out_valid_ff)
      else $error("result valid right after reset");

endmodule

### tb/sv/tb_reno_congestion_window_control.sv
`timescale 1ns / 100ps

// testbench for the reno congestion window controller
// events go in on the req stream, one result word per event comes back on rsp;
// a window model in this file mirrors the controller state (window, threshold,
// base, duplicate tracking, recovery) and predicts every result word, which
// the checker compares field by field in order of arrival
module tb_reno_congestion_window_control;
   import rcwc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 60;
   localparam int unsigned RANDOM_PHASES = 4;
   localparam int unsigned PHASE_EVENTS = 80;
   localparam int unsigned MAX_REPORTS = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;   // ack_number, send_pointer, final_sequence
   logic [0:0]  req_tuser = '0;   // func

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // congestion_window, threshold, effective_window, window_base,
   // base_advanced, in_fast_recovery, transfer_done, go_back, zero pad
   logic [79:0] rsp_tdata;

   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // mirror of the controller state, starts at the reset values
   logic [WIN_W-1:0]  win_cwnd = CWND_RST;
   logic [WIN_W-1:0]  win_thresh = INIT_THRESH_RST;
   logic [SEQ_W-1:0]  win_base = START_SEQ_RST;
   logic [SEQ_W-1:0]  dup_ack = '0;
   logic [1:0]        dup_cnt = '0;
   logic              in_recovery = 1'b0;
   logic [MAXW_W-1:0] cfg_max_window = MAX_WINDOW_RST;

   // predicted result words, oldest first
   result_type expected_words[$];

   int unsigned cycle_count = 0;
   int unsigned events_sent = 0;
   int unsigned words_checked = 0;
   int unsigned recovery_entries = 0;
   int unsigned timeouts_sent = 0;
   int unsigned mismatch_count = 0;

   // pacing controls
   bit req_gaps_on = 1'b0;
   bit rsp_gaps_on = 1'b0;
   bit hold_request = 1'b0;

   reno_congestion_window_control dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, expected_words.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // window update with saturation at the 16-bit limit
   function automatic logic [WIN_W-1:0] clamp_window(input longint unsigned v);
      return (v > WIN_LIMIT) ? WIN_LIMIT : v[WIN_W-1:0];
   endfunction

   // sequence offset that sticks at the top instead of wrapping
   function automatic logic [SEQ_W-1:0] seq_ahead(input logic [SEQ_W-1:0] s,
                                                  input int unsigned d);
      longint unsigned sum;
      sum = longint'(s) + d;
      return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[SEQ_W-1:0];
   endfunction

   // applies one event to the mirrored state and returns the word it should produce
   function automatic result_type predict_window(input logic func,
                                                 input logic [SEQ_W-1:0] ack,
                                                 input logic [SEQ_W-1:0] snd,
                                                 input logic [SEQ_W-1:0] fin);
      result_type r;
      longint unsigned acc;
      logic [MAXW_W-1:0] bound;
      r = '0;
      if (func == FUNC_TIMEOUT) begin
         // recovery flag, duplicate tracking and base survive a timeout
         win_thresh = win_cwnd >> 1;
         win_cwnd = CWND_RST;
         r.go_back = 1'b1;
      end else if (ack >= win_base && fin != '0 && ack == fin) begin
         // completion ack touches no state
         r.transfer_done = 1'b1;
      end else if (ack > win_base) begin
         if (in_recovery) begin
            if (ack >= snd) begin
               in_recovery = 1'b0;
               acc = win_thresh + RECOVERY_BONUS;
            end else begin
               // partial ack grows by the amount acknowledged
               acc = win_cwnd + (ack - win_base);
            end
         end else if (win_cwnd < win_thresh) begin
            acc = win_cwnd * 2;
         end else begin
            acc = win_cwnd + 1;
         end
         win_cwnd = clamp_window(acc);
         win_base = ack;
         dup_ack = ack;
         dup_cnt = '0;
         r.base_advanced = 1'b1;
      end else if (ack == win_base) begin
         if (ack != dup_ack) begin
            dup_ack = ack;
            dup_cnt = 2'd1;
         end else if (dup_cnt < DUP_TRIGGER) begin
            dup_cnt++;
            if (dup_cnt == DUP_TRIGGER) begin
               win_thresh = win_cwnd >> 1;
               acc = win_thresh + RECOVERY_BONUS;
               win_cwnd = clamp_window(acc);
               in_recovery = 1'b1;
               recovery_entries++;
            end
         end
      end
      // stale acks fall through with nothing changed
      bound = (cfg_max_window == '0) ? 11'd1 : cfg_max_window;
      r.congestion_window = win_cwnd;
      r.threshold = win_thresh;
      r.effective_window = (win_cwnd < bound) ? win_cwnd[MAXW_W-1:0] : bound;
      r.window_base = win_base;
      r.in_fast_recovery = in_recovery;
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.congestion_window = rsp_tdata[15:0];
         got.threshold = rsp_tdata[31:16];
         got.effective_window = rsp_tdata[42:32];
         got.window_base = rsp_tdata[74:43];
         got.base_advanced = rsp_tdata[75];
         got.in_fast_recovery = rsp_tdata[76];
         got.transfer_done = rsp_tdata[77];
         got.go_back = rsp_tdata[78];
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: result word with none expected: %h", $realtime, rsp_tdata);
         end else begin
            want = expected_words.pop_front();
            words_checked++;
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $write("%0t: word %0d mismatch cwnd %0d/%0d thresh %0d/%0d ",
                         $realtime, words_checked,
                         want.congestion_window, got.congestion_window,
                         want.threshold, got.threshold);
                  $write("eff %0d/%0d base %h/%h adv %b/%b ",
                         want.effective_window, got.effective_window,
                         want.window_base, got.window_base,
                         want.base_advanced, got.base_advanced);
                  $display("rec %b/%b done %b/%b goback %b/%b (expected/actual)",
                           want.in_fast_recovery, got.in_fast_recovery,
                           want.transfer_done, got.transfer_done,
                           want.go_back, got.go_back);
               end
            end
         end
      end
   end

   // rsp side pacing: a long hold-off on request, random stall bursts otherwise
   initial begin : rsp_pacing
      int unsigned hold_left;
      int unsigned gap;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--)
               @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (rsp_gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // offers one event word and records its prediction once it is taken;
   // tvalid stays high on return so back-to-back words need no gap
   task automatic send_event(input logic func, input logic [SEQ_W-1:0] ack,
                             input logic [SEQ_W-1:0] snd, input logic [SEQ_W-1:0] fin);
      int unsigned gap;
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {fin, snd, ack};
      req_tuser <= func;
      do @(posedge clock); while (!req_tready);
      expected_words.push_back(predict_window(func, ack, snd, fin));
      events_sent++;
      if (func == FUNC_TIMEOUT)
         timeouts_sent++;
   endtask

   // stop offering and wait until every predicted word came back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_MAX_WINDOW: cfg_max_window = value[MAXW_W-1:0];
         CSR_INIT_THRESH: win_thresh = value[WIN_W-1:0];
         CSR_START_SEQ: win_base = value;
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // one random event shaped around the current base: mostly well-formed ack
   // traffic, completions, duplicate runs and timeouts, with some stale and raw noise
   task automatic send_random_event();
      int unsigned pick;
      int unsigned runs;
      logic [SEQ_W-1:0] ack;
      logic [SEQ_W-1:0] snd;
      logic [SEQ_W-1:0] fin;
      pick = $urandom_range(0, 99);
      fin = ($urandom_range(0, 3) == 0) ? $urandom : '0;
      snd = seq_ahead(win_base, $urandom_range(1, 64));
      if (pick < 8) begin
         send_event(FUNC_TIMEOUT, $urandom, $urandom, $urandom);
      end else if (pick < 26) begin
         // duplicate run of one to four acks, sometimes long enough to enter recovery
         runs = $urandom_range(1, 4);
         repeat (runs) send_event(FUNC_ACK, win_base, snd, '0);
      end else if (pick < 64) begin
         ack = seq_ahead(win_base, $urandom_range(1, 32));
         if (in_recovery && $urandom_range(0, 1) == 0)
            snd = seq_ahead(ack, $urandom_range(1, 40));   // partial ack
         else if (in_recovery)
            snd = ack - $urandom_range(0, 2);              // full ack
         send_event(FUNC_ACK, ack, snd, fin);
      end else if (pick < 71) begin
         ack = win_base - ((win_base < 100) ? win_base : $urandom_range(1, 100));
         send_event(FUNC_ACK, ack, snd, fin);
      end else if (pick < 79) begin
         ack = seq_ahead(win_base, $urandom_range(0, 8));
         send_event(FUNC_ACK, ack, snd, ack);
      end else if (pick < 85) begin
         // completion number below the base does not count
         ack = win_base - ((win_base == 0) ? 0 : $urandom_range(1, 4));
         send_event(FUNC_ACK, ack, snd, ack);
      end else begin
         send_event(logic'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
      end
   endtask

   // reset values: slow start doubles up to the threshold, then grows by one
   task automatic test_slow_start();
      int unsigned i;
      for (i = 3; i <= 7; i++)
         send_event(FUNC_ACK, i, 32'd100, '0);
   endtask

   // three duplicates enter recovery, a fourth does nothing, a partial ack
   // adds the acked amount, an ack at the send pointer leaves recovery
   task automatic test_fast_recovery();
      repeat (4) send_event(FUNC_ACK, 32'd7, 32'd100, '0);
      send_event(FUNC_ACK, 32'd10, 32'd100, '0);
      send_event(FUNC_ACK, 32'd100, 32'd100, '0);
   endtask

   // timeout keeps the recovery flag, so the next ack is a partial one
   task automatic test_timeout();
      repeat (3) send_event(FUNC_ACK, 32'd100, 32'd200, '0);
      send_event(FUNC_TIMEOUT, 32'd100, 32'd200, '0);
      send_event(FUNC_ACK, 32'd105, 32'd200, '0);
   endtask

   // completion, completion number below the base, unknown final sequence
   task automatic test_completion_and_stale();
      send_event(FUNC_ACK, 32'd110, 32'd200, 32'd110);
      send_event(FUNC_ACK, 32'd50, 32'd200, 32'd50);
      send_event(FUNC_ACK, 32'd111, 32'd200, '0);
   endtask

   // all-ones and all-zero fields, base driven to the top of the range
   task automatic test_field_extremes();
      send_event(FUNC_ACK, '1, '1, '1);
      send_event(FUNC_ACK, '1, '0, '0);
      send_event(FUNC_ACK, '0, '0, '0);
      send_event(FUNC_TIMEOUT, '1, '1, '1);
   endtask

   // register corners: zero max window, zero threshold, zero base,
   // saturation on recovery exit and on a huge partial ack
   task automatic test_register_corners();
      write_csr(CSR_MAX_WINDOW, 32'd0);
      write_csr(CSR_INIT_THRESH, 32'd0);
      write_csr(CSR_START_SEQ, 32'd0);
      send_event(FUNC_ACK, 32'd1, 32'd10, '0);
      repeat (3) send_event(FUNC_ACK, 32'd1, 32'd10, '0);
      write_csr(CSR_INIT_THRESH, 32'h0000_FFFF);
      write_csr(CSR_MAX_WINDOW, 32'd1024);
      send_event(FUNC_ACK, 32'd20, 32'd20, '0);
      repeat (3) send_event(FUNC_ACK, 32'd20, 32'hFFFF_FFFF, '0);
      send_event(FUNC_ACK, 32'hF000_0000, 32'hFFFF_FFFF, '0);
      write_csr(CSR_MAX_WINDOW, 32'd2047);
      write_csr(CSR_UNUSED, 32'hFFFF_FFFF);
      send_event(FUNC_ACK, 32'hF000_0001, 32'hFFFF_FFFF, '0);
   endtask

   // random traffic under several register settings with idling on both sides
   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned n;
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_MAX_WINDOW, 32'd1);
               write_csr(CSR_INIT_THRESH, 32'd0);
               write_csr(CSR_START_SEQ, 32'hFFFF_FF00);
            end
            1: begin
               write_csr(CSR_MAX_WINDOW, 32'd1024);
               write_csr(CSR_INIT_THRESH, 32'h0000_FFFF);
               write_csr(CSR_START_SEQ, 32'h8000_0000);
            end
            default: begin
               write_csr(CSR_MAX_WINDOW, $urandom_range(1, 1024));
               write_csr(CSR_INIT_THRESH, $urandom_range(0, 64));
               write_csr(CSR_START_SEQ, $urandom);
            end
         endcase
         for (n = 0; n < PHASE_EVENTS; n++)
            send_random_event();
      end
      wait_idle();
   endtask

   // rsp side holds off for a long stretch while events keep coming,
   // so the controller fills up and drops req_tready
   task automatic test_backpressure();
      int unsigned n;
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      hold_request = 1'b1;
      for (n = 0; n < 30; n++)
         send_random_event();
      wait_idle();
   endtask

   // last stretch: back-to-back words, no idling on either side
   task automatic test_back_to_back();
      int unsigned n;
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      for (n = 0; n < 60; n++)
         send_random_event();
      wait_idle();
   endtask

   initial begin : run
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_slow_start();
      test_fast_recovery();
      test_timeout();
      test_completion_and_stale();
      test_field_extremes();
      test_register_corners();
      test_random_traffic();
      test_backpressure();
      test_back_to_back();
      repeat (4) @(posedge clock);
      $display("%0d events sent (%0d timeouts), %0d result words checked, %0d mismatches",
               events_sent, timeouts_sent, words_checked, mismatch_count);
      $display("covered slow start, %0d recovery entries, completion, stale acks, %s",
               recovery_entries, "saturation and register corners under backpressure");
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### filelist.f
hdl/rcwc_pkg.sv
hdl/rcwc_update.sv
hdl/reno_congestion_window_control.sv
tb/sv/tb_reno_congestion_window_control.sv
